### hw/rtl/skf_pkg.sv
// Shared constants for the scalar Kalman filter: data widths, default scaling, register indexes.
package skf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned NOISE_W       = 31;
  localparam int unsigned CFG_ADDR_W    = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_PROCESS_NOISE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MEASURE_NOISE   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TRANSITION_GAIN = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OBSERVE_GAIN    = 2'd3;

endpackage

### hw/rtl/scalar_kalman_filter.sv
// One-dimensional fixed-point Kalman filter built around one shared multiplier and adder.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------------
//   config   | cfg_we_i                | cfg_addr_i, cfg_wdata_i
//   input    | in_valid_i / in_ready_o | measurement_i
//   output   | out_valid_o/out_ready_i | estimate_o, kalman_gain_o, zero_divisor_o
//
// Each beat runs nine fixed-point products through one 32x32 multiplier, each passing through
// multiply, scale and saturate, and add and saturate, plus a restoring divider that retires two
// quotient bits a cycle; the division is skipped when the gain divisor is zero.
// in_ready_o is high only while the sequencer is idle; a finished result waits in the output
// register, and the next one is held back only until that beat has been taken.
// Reset clears the estimate and covariance and loads A = H = 1.0, q = r = 0.
module scalar_kalman_filter #(
  parameter int unsigned FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [skf_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [skf_pkg::DATA_W-1:0]           cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [skf_pkg::DATA_W-1:0]    measurement_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [skf_pkg::DATA_W-1:0]    estimate_o,
  output logic signed [skf_pkg::DATA_W-1:0]    kalman_gain_o,
  output logic                                 zero_divisor_o
);

  localparam int unsigned DIV_W     = 32 + FRAC_BITS + ((32 + FRAC_BITS) % 2);
  localparam int unsigned DIV_STEPS = DIV_W / 2;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic signed [31:0]  ONE       = 32'sd1 <<< FRAC_BITS;
  localparam logic [DIV_W-1:0]    Q_POS_MAX = DIV_W'(32'h7fff_ffff);
  localparam logic [DIV_W-1:0]    Q_NEG_MAX = DIV_W'(32'h8000_0000);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_ACC    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_DIVEND = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [3:0] OP_X   = 4'd0;  // A * x
  localparam logic [3:0] OP_AA  = 4'd1;  // A * A
  localparam logic [3:0] OP_P   = 4'd2;  // (A*A) * p + q
  localparam logic [3:0] OP_PH  = 4'd3;  // p * H
  localparam logic [3:0] OP_DEN = 4'd4;  // (p*H) * H + r
  localparam logic [3:0] OP_HX  = 4'd5;  // z - H * x
  localparam logic [3:0] OP_KI  = 4'd6;  // x + K * innovation
  localparam logic [3:0] OP_KH  = 4'd7;  // 1 - K * H
  localparam logic [3:0] OP_OP  = 4'd8;  // (1 - K*H) * p

  logic [2:0]              state_q;
  logic [3:0]              op_q;
  logic [CNT_W-1:0]        div_cnt_q;
  logic                    out_valid_q;
  logic [30:0]             proc_noise_q;
  logic [30:0]             meas_noise_q;
  logic signed [31:0]      trans_q;
  logic signed [31:0]      obs_q;
  logic signed [31:0]      est_q;
  logic signed [31:0]      cov_q;

  logic signed [31:0]      z_q;
  logic signed [31:0]      t_q;
  logic signed [31:0]      ph_q;
  logic signed [31:0]      k_q;
  logic                    zero_q;
  logic signed [63:0]      prod_q;
  logic signed [31:0]      qv_q;
  logic [32:0]             rem_q;
  logic [DIV_W-1:0]        quo_q;
  logic [31:0]             dmag_q;
  logic                    div_neg_q;

  logic signed [31:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic signed [63:0]      prod_sh;
  logic signed [31:0]      qv_sat;
  logic signed [33:0]      add_a;
  logic signed [33:0]      add_b;
  logic                    add_sub;
  logic signed [33:0]      add_sum;
  logic signed [31:0]      add_sat;
  logic                    den_zero;
  logic [31:0]             ph_mag;
  logic [31:0]             den_mag;
  logic [32:0]             rem_nxt;
  logic [DIV_W-1:0]        quo_nxt;
  logic signed [31:0]      k_div;
  logic                    out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (op_q)
      OP_X:    begin mul_a = trans_q; mul_b = est_q;   end
      OP_AA:   begin mul_a = trans_q; mul_b = trans_q; end
      OP_P:    begin mul_a = t_q;     mul_b = cov_q;   end
      OP_PH:   begin mul_a = cov_q;   mul_b = obs_q;   end
      OP_DEN:  begin mul_a = ph_q;    mul_b = obs_q;   end
      OP_HX:   begin mul_a = obs_q;   mul_b = est_q;   end
      OP_KI:   begin mul_a = k_q;     mul_b = t_q;     end
      OP_KH:   begin mul_a = k_q;     mul_b = obs_q;   end
      OP_OP:   begin mul_a = t_q;     mul_b = cov_q;   end
      default: begin mul_a = '0;      mul_b = '0;      end
    endcase
  end

  // The arithmetic shift floors the scaled product before saturation.
  always_comb begin
    prod_sh = prod_q >>> FRAC_BITS;
    if (prod_sh > 64'sd2147483647) begin
      qv_sat = 32'sh7fff_ffff;
    end else if (prod_sh < -64'sd2147483648) begin
      qv_sat = 32'sh8000_0000;
    end else begin
      qv_sat = prod_sh[31:0];
    end
  end

  // Shared adder with saturation to 32 bits.
  always_comb begin
    add_a   = 34'(qv_q);
    add_b   = '0;
    add_sub = 1'b0;
    case (op_q)
      OP_P:    add_b = {3'b000, proc_noise_q};
      OP_DEN:  add_b = {3'b000, meas_noise_q};
      OP_HX:   begin add_a = 34'(z_q); add_b = 34'(qv_q); add_sub = 1'b1; end
      OP_KI:   add_b = 34'(est_q);
      OP_KH:   begin add_a = 34'(ONE); add_b = 34'(qv_q); add_sub = 1'b1; end
      default: add_b = '0;
    endcase
    add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
    if (add_sum > 34'sd2147483647) begin
      add_sat = 32'sh7fff_ffff;
    end else if (add_sum < -34'sd2147483648) begin
      add_sat = 32'sh8000_0000;
    end else begin
      add_sat = add_sum[31:0];
    end
    den_zero = (add_sat == 32'sd0);
  end

  assign ph_mag  = ph_q[31] ? 32'(-ph_q) : 32'(ph_q);
  assign den_mag = add_sat[31] ? 32'(-add_sat) : 32'(add_sat);

  // Two restoring division steps per cycle; the dividend shifts out of quo_q as quotient bits
  // shift in.
  always_comb begin
    rem_nxt = rem_q;
    quo_nxt = quo_q;
    for (int i = 0; i < 2; i++) begin
      rem_nxt = {rem_nxt[31:0], quo_nxt[DIV_W-1]};
      quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, dmag_q}) begin
        rem_nxt    = rem_nxt - {1'b0, dmag_q};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  always_comb begin
    if (!div_neg_q) begin
      k_div = (quo_q > Q_POS_MAX) ? 32'sh7fff_ffff : $signed(quo_q[31:0]);
    end else begin
      k_div = (quo_q > Q_NEG_MAX) ? 32'sh8000_0000 : $signed(32'(-quo_q[31:0]));
    end
  end

  // Sequencer, configuration and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_X;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      proc_noise_q <= '0;
      meas_noise_q <= '0;
      trans_q      <= ONE;
      obs_q        <= ONE;
      est_q        <= '0;
      cov_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          skf_pkg::REG_PROCESS_NOISE:   proc_noise_q <= cfg_wdata_i[30:0];
          skf_pkg::REG_MEASURE_NOISE:   meas_noise_q <= cfg_wdata_i[30:0];
          skf_pkg::REG_TRANSITION_GAIN: trans_q      <= $signed(cfg_wdata_i);
          skf_pkg::REG_OBSERVE_GAIN:    obs_q        <= $signed(cfg_wdata_i);
        endcase
      end

      // A beat taken while the next result is ready is replaced in the done state.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_MUL;
            op_q    <= OP_X;
          end
        end
        S_MUL:   state_q <= S_SHIFT;
        S_SHIFT: state_q <= S_ACC;
        S_ACC: begin
          case (op_q)
            OP_X:  est_q <= qv_q;
            OP_P:  cov_q <= add_sat[31] ? 32'sd0 : add_sat;
            OP_KI: est_q <= add_sat;
            OP_OP: cov_q <= qv_q[31] ? 32'sd0 : qv_q;
            default: ;
          endcase
          if (op_q == OP_OP) begin
            state_q <= S_DONE;
          end else if (op_q == OP_DEN && !den_zero) begin
            state_q   <= S_DIV;
            div_cnt_q <= '0;
          end else begin
            state_q <= S_MUL;
            op_q    <= op_q + 4'd1;
          end
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + CNT_W'(1);
          if (div_cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            state_q <= S_DIVEND;
          end
        end
        S_DIVEND: begin
          state_q <= S_MUL;
          op_q    <= OP_HX;
        end
        S_DONE: begin
          if (out_free) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      z_q <= measurement_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == S_SHIFT) begin
      qv_q <= qv_sat;
    end
    if (state_q == S_ACC) begin
      case (op_q)
        OP_AA:  t_q  <= qv_q;
        OP_PH:  ph_q <= qv_q;
        OP_HX:  t_q  <= add_sat;
        OP_KH:  t_q  <= add_sat;
        OP_DEN: begin
          zero_q    <= den_zero;
          k_q       <= '0;
          dmag_q    <= den_mag;
          div_neg_q <= ph_q[31] ^ add_sat[31];
          rem_q     <= '0;
          quo_q     <= DIV_W'({ph_mag, {FRAC_BITS{1'b0}}});
        end
        default: ;
      endcase
    end
    if (state_q == S_DIV) begin
      rem_q <= rem_nxt;
      quo_q <= quo_nxt;
    end
    if (state_q == S_DIVEND) begin
      k_q <= k_div;
    end
    if (state_q == S_DONE && out_free) begin
      estimate_o     <= est_q;
      kalman_gain_o  <= k_q;
      zero_divisor_o <= zero_q;
    end
  end

  a_div_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_cnt_q < CNT_W'(DIV_STEPS)))
    else $error("division step count ran past the quotient width");

  a_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_divisor_o) |-> (kalman_gain_o == 32'sd0))
    else $error("gain not zero on a beat flagged with a zero divisor");

  a_cov_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cov_q[31])
    else $error("covariance went negative");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sequencer stayed idle after taking a measurement");

endmodule
